@@ rtl/core/opepc_pkg.sv @@
// Shared types, constants and helpers for the odd prime / even perfect counter.
package opepc_pkg;

    localparam int VALUE_WIDTH = 16;
    localparam int COUNT_WIDTH = 11;
    localparam int ROOT_WIDTH  = VALUE_WIDTH / 2 + 1;
    localparam int TALLY_WIDTH = ROOT_WIDTH + 1;
    localparam int SUM_WIDTH   = VALUE_WIDTH + 3;
    localparam int STEP_WIDTH  = $clog2(VALUE_WIDTH);
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    typedef struct packed {
        logic [VALUE_WIDTH-1:0] value;
        logic                   last;
    } in_beat_t;

    typedef struct packed {
        logic                   is_even;
        logic                   is_odd_prime;
        logic                   is_even_perfect;
        logic [COUNT_WIDTH-1:0] even_total;
        logic [COUNT_WIDTH-1:0] odd_total;
        logic [COUNT_WIDTH-1:0] odd_prime_total;
        logic [COUNT_WIDTH-1:0] even_perfect_total;
        logic                   set_done;
    } out_beat_t;

    typedef struct packed {
        logic [VALUE_WIDTH-1:0] value;
        logic                   last;
        logic                   is_even;
        logic                   is_zero;
    } job_t;

    typedef struct packed {
        logic valid;
        job_t job;
    } queue_head_t;

    typedef struct packed {
        logic                   start;
        logic [VALUE_WIDTH-1:0] dividend;
        logic [ROOT_WIDTH-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic                   done;
        logic [VALUE_WIDTH-1:0] quotient;
        logic                   rem_zero;
    } div_rsp_t;

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
        return (c == COUNT_MAX) ? c : c + COUNT_WIDTH'(1);
    endfunction

endpackage

@@ rtl/core/opepc_divider.sv @@
// Restoring divider that produces one quotient bit per cycle.
module opepc_divider
    import opepc_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [STEP_WIDTH-1:0]  step_reg, step_next;
    logic [ROOT_WIDTH-1:0]  rem_reg, rem_next;
    logic [VALUE_WIDTH-1:0] quo_reg, quo_next;
    logic [ROOT_WIDTH-1:0]  divisor_reg, divisor_next;
    logic [ROOT_WIDTH:0]    partial;
    logic [ROOT_WIDTH:0]    diff;
    logic                   fits;

    always_comb begin
        partial      = {rem_reg, quo_reg[VALUE_WIDTH-1]};
        diff         = partial - {1'b0, divisor_reg};
        fits         = partial >= {1'b0, divisor_reg};
        busy_next    = busy_reg;
        done_next    = 1'b0;
        step_next    = step_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        divisor_next = divisor_reg;
        if (req.start) begin
            busy_next    = 1'b1;
            step_next    = '0;
            rem_next     = '0;
            quo_next     = req.dividend;
            divisor_next = req.divisor;
        end else if (busy_reg) begin
            rem_next  = fits ? diff[ROOT_WIDTH-1:0] : partial[ROOT_WIDTH-1:0];
            quo_next  = {quo_reg[VALUE_WIDTH-2:0], fits};
            step_next = step_reg + STEP_WIDTH'(1);
            if (step_reg == STEP_WIDTH'(VALUE_WIDTH - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        step_reg    <= step_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        divisor_reg <= divisor_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;
    assign rsp.rem_zero = (rem_reg == '0);

endmodule

@@ rtl/core/opepc_back.sv @@
// Back end: divisor scan, flag decision, set totals and output register.
module opepc_back
    import opepc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  queue_head_t head,
    output logic        job_ready,
    output logic        m_valid,
    input  logic        m_ready,
    output out_beat_t   m_beat
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_CHECK  = 2'd1;
    localparam logic [1:0] ST_WAIT   = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0]             state_reg, state_next;
    job_t                   job_reg, job_next;
    logic [ROOT_WIDTH-1:0]  d_reg, d_next;
    logic [VALUE_WIDTH:0]   sq_reg, sq_next;
    logic [TALLY_WIDTH-1:0] tally_reg, tally_next;
    logic [SUM_WIDTH-1:0]   sum_reg, sum_next;
    logic [COUNT_WIDTH-1:0] even_cnt_reg, even_cnt_next;
    logic [COUNT_WIDTH-1:0] odd_cnt_reg, odd_cnt_next;
    logic [COUNT_WIDTH-1:0] prime_cnt_reg, prime_cnt_next;
    logic [COUNT_WIDTH-1:0] perf_cnt_reg, perf_cnt_next;
    logic                   out_valid_reg, out_valid_next;
    out_beat_t              out_beat_reg, out_beat_next;
    div_req_t               div_req;
    div_rsp_t               div_rsp;
    logic                   prime;
    logic                   perfect;
    logic [COUNT_WIDTH-1:0] even_new, odd_new, prime_new, perf_new;

    opepc_divider u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    always_comb begin
        prime    = !job_reg.is_even && (tally_reg == TALLY_WIDTH'(2));
        perfect  = job_reg.is_even && !job_reg.is_zero
                   && (sum_reg == SUM_WIDTH'({job_reg.value, 1'b0}));
        even_new  = job_reg.is_even ? sat_inc(even_cnt_reg) : even_cnt_reg;
        odd_new   = job_reg.is_even ? odd_cnt_reg : sat_inc(odd_cnt_reg);
        prime_new = prime ? sat_inc(prime_cnt_reg) : prime_cnt_reg;
        perf_new  = perfect ? sat_inc(perf_cnt_reg) : perf_cnt_reg;

        state_next     = state_reg;
        job_next       = job_reg;
        d_next         = d_reg;
        sq_next        = sq_reg;
        tally_next     = tally_reg;
        sum_next       = sum_reg;
        even_cnt_next  = even_cnt_reg;
        odd_cnt_next   = odd_cnt_reg;
        prime_cnt_next = prime_cnt_reg;
        perf_cnt_next  = perf_cnt_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_beat_next  = out_beat_reg;
        job_ready      = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = job_reg.value;
        div_req.divisor  = d_reg;

        unique case (state_reg)
            ST_IDLE: begin
                job_ready = 1'b1;
                if (head.valid) begin
                    job_next   = head.job;
                    d_next     = ROOT_WIDTH'(1);
                    sq_next    = (VALUE_WIDTH + 1)'(1);
                    tally_next = '0;
                    sum_next   = '0;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (sq_reg <= {1'b0, job_reg.value}) begin
                    div_req.start = 1'b1;
                    state_next    = ST_WAIT;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_WAIT: begin
                if (div_rsp.done) begin
                    if (div_rsp.rem_zero) begin
                        if (div_rsp.quotient != VALUE_WIDTH'(d_reg)) begin
                            tally_next = tally_reg + TALLY_WIDTH'(2);
                            sum_next   = sum_reg + SUM_WIDTH'(d_reg)
                                         + SUM_WIDTH'(div_rsp.quotient);
                        end else begin
                            tally_next = tally_reg + TALLY_WIDTH'(1);
                            sum_next   = sum_reg + SUM_WIDTH'(d_reg);
                        end
                    end
                    d_next     = d_reg + ROOT_WIDTH'(1);
                    sq_next    = sq_reg + (VALUE_WIDTH + 1)'({d_reg, 1'b1});
                    state_next = ST_CHECK;
                end
            end
            ST_FINISH: begin
                if (!out_valid_reg || m_ready) begin
                    out_valid_next = 1'b1;
                    out_beat_next.is_even            = job_reg.is_even;
                    out_beat_next.is_odd_prime       = prime;
                    out_beat_next.is_even_perfect    = perfect;
                    out_beat_next.even_total         = even_new;
                    out_beat_next.odd_total          = odd_new;
                    out_beat_next.odd_prime_total    = prime_new;
                    out_beat_next.even_perfect_total = perf_new;
                    out_beat_next.set_done           = job_reg.last;
                    even_cnt_next  = job_reg.last ? '0 : even_new;
                    odd_cnt_next   = job_reg.last ? '0 : odd_new;
                    prime_cnt_next = job_reg.last ? '0 : prime_new;
                    perf_cnt_next  = job_reg.last ? '0 : perf_new;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            even_cnt_reg  <= '0;
            odd_cnt_reg   <= '0;
            prime_cnt_reg <= '0;
            perf_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            even_cnt_reg  <= even_cnt_next;
            odd_cnt_reg   <= odd_cnt_next;
            prime_cnt_reg <= prime_cnt_next;
            perf_cnt_reg  <= perf_cnt_next;
            out_valid_reg <= out_valid_next;
        end
        job_reg      <= job_next;
        d_reg        <= d_next;
        sq_reg       <= sq_next;
        tally_reg    <= tally_next;
        sum_reg      <= sum_next;
        out_beat_reg <= out_beat_next;
    end

    assign m_valid = out_valid_reg;
    assign m_beat  = out_beat_reg;

    a_start_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        div_req.start |=> (state_reg == ST_WAIT))
        else $error("Divider started without the scan waiting for it.");

    a_done_rechecks: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WAIT && div_rsp.done) |=> (state_reg == ST_CHECK))
        else $error("Scan did not return to the bound check after a division.");

    a_write_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINISH && (!out_valid_reg || m_ready))
        |=> (out_valid_reg && state_reg == ST_IDLE))
        else $error("Finished item was not placed in the output register.");

    a_flags_parity: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> !(out_beat_reg.is_odd_prime && out_beat_reg.is_even)
                          && !(out_beat_reg.is_even_perfect && !out_beat_reg.is_even))
        else $error("Result flags disagree with the parity of the value.");

endmodule

@@ rtl/core/opepc_front.sv @@
// Front end: accepts input beats, classifies parity and queues jobs.
module opepc_front
    import opepc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_beat_t    s_beat,
    output queue_head_t head,
    input  logic        job_ready
);

    job_t                  queue_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]     count_reg, count_next;
    logic                  push;
    logic                  pop;
    job_t                  job_in;

    always_comb begin
        job_in.value   = s_beat.value;
        job_in.last    = s_beat.last;
        job_in.is_even = !s_beat.value[0];
        job_in.is_zero = (s_beat.value == '0);
        s_ready        = (count_reg != (QUEUE_AW + 1)'(QUEUE_DEPTH));
        push           = s_valid && s_ready;
        head.valid     = (count_reg != '0);
        head.job       = queue_mem[rd_ptr_reg];
        pop            = head.valid && job_ready;
        wr_ptr_next    = push ? wr_ptr_reg + QUEUE_AW'(1) : wr_ptr_reg;
        rd_ptr_next    = pop ? rd_ptr_reg + QUEUE_AW'(1) : rd_ptr_reg;
        count_next     = count_reg + (QUEUE_AW + 1)'(push) - (QUEUE_AW + 1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            queue_mem[wr_ptr_reg] <= job_in;
        end
    end

endmodule

@@ rtl/core/odd_prime_even_perfect_counter.sv @@
// Top level of the odd prime / even perfect counter.
//
//   Channel | Ports                        | Beat
//   input   | s_valid, s_ready, s_beat     | value to classify, last of set
//   result  | m_valid, m_ready, m_beat     | flags and running set totals
//
// The back end takes one item at a time and tries each divisor up to floor(sqrt(value)) with its
// one-bit-per-cycle divider.
// The front end keeps accepting beats into a four-entry queue while the back end works, until the queue is full.
// A finished result waits in the output register while the next item is scanned.
// Reset is synchronous and active low; it empties the queue and clears the set totals.
module odd_prime_even_perfect_counter
    import opepc_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_beat_t  s_beat,
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_beat
);

    queue_head_t head;
    logic        job_ready;

    opepc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_beat    (s_beat),
        .head      (head),
        .job_ready (job_ready)
    );

    opepc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head      (head),
        .job_ready (job_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_beat    (m_beat)
    );

endmodule
